// ===== rtl/core/gdds_pkg.sv =====
package gdds_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OffW    = 17;
  // Working day count: covers day-of-month plus any offset, with sign.
  localparam int unsigned WorkW   = 18;

  localparam logic [YearW-1:0]  YearMin     = 14'd1;
  localparam logic [YearW-1:0]  YearMax     = 14'd9999;
  localparam logic [YearW-1:0]  DefaultYear = 14'd1900;
  localparam logic [MonthW-1:0] MonthJan    = 4'd1;
  localparam logic [MonthW-1:0] MonthDec    = 4'd12;
  localparam logic [DayW-1:0]   DayFirst    = 5'd1;
  localparam logic [DayW-1:0]   DecemberLen = 5'd31;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LOAD = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_SHIFT = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic settled;
    logic bad;
  } sts_t;

  // Leap-year test. The quotient by 100 comes from a reciprocal multiply,
  // exact for every 14-bit year.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [26:0]      prod;
    logic [7:0]       q;
    logic [YearW-1:0] hund;
    prod = y * 13'd5243;
    q    = prod[26:19];
    hund = {q, 6'b0} + 14'({q, 5'b0}) + 14'({q, 2'b0});
    return (y[1:0] == 2'b00) && ((hund != y) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28 + 5'(leap);
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DayW-1:0] days_in(input logic [YearW-1:0] y,
                                              input logic [MonthW-1:0] m);
    return month_len(m, is_leap(y));
  endfunction

  function automatic logic [8:0] year_len(input logic [YearW-1:0] y);
    return 9'd365 + 9'(is_leap(y));
  endfunction

endpackage

// ===== rtl/core/gdds_dp.sv =====
module gdds_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gdds_pkg::cmd_t                   cmd_i,
  input  logic [gdds_pkg::YearW-1:0]       new_year_i,
  input  logic [gdds_pkg::MonthW-1:0]      new_month_i,
  input  logic [gdds_pkg::DayW-1:0]        new_day_i,
  input  logic signed [gdds_pkg::OffW-1:0] day_offset_i,
  output gdds_pkg::sts_t                   sts_o,
  output logic [gdds_pkg::YearW-1:0]       cur_year_o,
  output logic [gdds_pkg::MonthW-1:0]      cur_month_o,
  output logic [gdds_pkg::DayW-1:0]        cur_day_o,
  output gdds_pkg::status_e                status_o
);

  logic [gdds_pkg::YearW-1:0]        date_year_q, date_year_d;
  logic [gdds_pkg::MonthW-1:0]       date_month_q, date_month_d;
  logic [gdds_pkg::DayW-1:0]         date_day_q, date_day_d;
  gdds_pkg::status_e                 status_q, status_d;

  logic [gdds_pkg::YearW-1:0]        wy_q, wy_d;
  logic [gdds_pkg::MonthW-1:0]       wm_q, wm_d;
  logic signed [gdds_pkg::WorkW-1:0] wd_q, wd_d;

  logic                              load_ok;
  logic [gdds_pkg::DayW-1:0]         load_len;
  logic [gdds_pkg::DayW-1:0]         mlen_cur, mlen_prev;
  logic [8:0]                        ylen_cur, ylen_prev;
  logic [gdds_pkg::YearW-1:0]        wy_dec;
  logic signed [gdds_pkg::WorkW-1:0] mlen_cur_s, mlen_prev_s, ylen_cur_s, ylen_prev_s;
  logic signed [gdds_pkg::WorkW-1:0] wd_plus_year;
  logic                              fwd, bwd, fwd_year;
  logic                              bad;

  assign load_len = gdds_pkg::days_in(new_year_i, new_month_i);
  assign load_ok  = (new_year_i >= gdds_pkg::YearMin) && (new_year_i <= gdds_pkg::YearMax) &&
                    (new_day_i != '0) && (new_day_i <= load_len);

  assign wy_dec      = wy_q - gdds_pkg::YearMin;
  assign mlen_cur    = gdds_pkg::days_in(wy_q, wm_q);
  assign mlen_prev   = gdds_pkg::days_in(wy_q, wm_q - gdds_pkg::MonthJan);
  assign ylen_cur    = gdds_pkg::year_len(wy_q);
  assign ylen_prev   = gdds_pkg::year_len(wy_dec);
  assign mlen_cur_s  = $signed({13'd0, mlen_cur});
  assign mlen_prev_s = $signed({13'd0, mlen_prev});
  assign ylen_cur_s  = $signed({9'd0, ylen_cur});
  assign ylen_prev_s = $signed({9'd0, ylen_prev});
  assign wd_plus_year = wd_q + ylen_prev_s;

  // Forward when the day runs past the month, backward when it is not positive.
  assign fwd      = wd_q > mlen_cur_s;
  assign bwd      = wd_q[gdds_pkg::WorkW-1] || (wd_q == '0);
  assign fwd_year = (wm_q == gdds_pkg::MonthJan) && (wd_q > ylen_cur_s);

  assign bad = (fwd && (wy_q == gdds_pkg::YearMax) &&
                ((wm_q == gdds_pkg::MonthDec) || fwd_year)) ||
               (bwd && (wm_q == gdds_pkg::MonthJan) && (wy_q == gdds_pkg::YearMin));

  assign sts_o.settled = !fwd && !bwd;
  assign sts_o.bad     = bad;

  always_comb begin
    wy_d = wy_q;
    wm_d = wm_q;
    wd_d = wd_q;
    if (cmd_i.start) begin
      wy_d = date_year_q;
      wm_d = date_month_q;
      wd_d = $signed({13'd0, date_day_q}) + 18'(day_offset_i);
    end else if (cmd_i.step) begin
      if (fwd) begin
        if (fwd_year) begin
          // A whole year from January 1 onward.
          wy_d = wy_q + gdds_pkg::YearMin;
          wd_d = wd_q - ylen_cur_s;
        end else begin
          wd_d = wd_q - mlen_cur_s;
          if (wm_q == gdds_pkg::MonthDec) begin
            wm_d = gdds_pkg::MonthJan;
            wy_d = wy_q + gdds_pkg::YearMin;
          end else begin
            wm_d = wm_q + gdds_pkg::MonthJan;
          end
        end
      end else if (bwd) begin
        if (wm_q == gdds_pkg::MonthJan) begin
          wy_d = wy_dec;
          if (wd_plus_year[gdds_pkg::WorkW-1] || (wd_plus_year == '0)) begin
            // The whole previous year still leaves the day not positive.
            wd_d = wd_plus_year;
          end else begin
            wm_d = gdds_pkg::MonthDec;
            wd_d = wd_q + $signed({13'd0, gdds_pkg::DecemberLen});
          end
        end else begin
          wm_d = wm_q - gdds_pkg::MonthJan;
          wd_d = wd_q + mlen_prev_s;
        end
      end
    end
  end

  always_comb begin
    date_year_d  = date_year_q;
    date_month_d = date_month_q;
    date_day_d   = date_day_q;
    status_d     = status_q;
    if (cmd_i.load) begin
      if (load_ok) begin
        date_year_d  = new_year_i;
        date_month_d = new_month_i;
        date_day_d   = new_day_i;
        status_d     = gdds_pkg::STATUS_OK;
      end else begin
        date_year_d  = gdds_pkg::DefaultYear;
        date_month_d = gdds_pkg::MonthJan;
        date_day_d   = gdds_pkg::DayFirst;
        status_d     = gdds_pkg::STATUS_BAD_LOAD;
      end
    end else if (cmd_i.finish) begin
      if (bad) begin
        status_d = gdds_pkg::STATUS_RANGE;
      end else begin
        date_year_d  = wy_q;
        date_month_d = wm_q;
        date_day_d   = wd_q[gdds_pkg::DayW-1:0];
        status_d     = gdds_pkg::STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_year_q  <= gdds_pkg::DefaultYear;
      date_month_q <= gdds_pkg::MonthJan;
      date_day_q   <= gdds_pkg::DayFirst;
      status_q     <= gdds_pkg::STATUS_OK;
    end else begin
      date_year_q  <= date_year_d;
      date_month_q <= date_month_d;
      date_day_q   <= date_day_d;
      status_q     <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wy_q <= wy_d;
    wm_q <= wm_d;
    wd_q <= wd_d;
  end

  assign cur_year_o  = date_year_q;
  assign cur_month_o = date_month_q;
  assign cur_day_o   = date_day_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/core/gdds_ctrl.sv =====
module gdds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           req_type_i,
  input  logic           out_ready_i,
  input  gdds_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output gdds_pkg::cmd_t cmd_o
);

  gdds_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gdds_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (req_type_i == gdds_pkg::REQ_SHIFT) ? gdds_pkg::S_STEP : gdds_pkg::S_OUT;
        end
      end
      gdds_pkg::S_STEP: begin
        if (sts_i.settled || sts_i.bad) begin
          state_d = gdds_pkg::S_OUT;
        end
      end
      gdds_pkg::S_OUT: begin
        if (out_ready_i) begin
          state_d = gdds_pkg::S_IDLE;
        end
      end
      default: state_d = gdds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      gdds_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i && (req_type_i == gdds_pkg::REQ_LOAD);
        cmd_o.start  = in_valid_i && (req_type_i == gdds_pkg::REQ_SHIFT);
      end
      gdds_pkg::S_STEP: begin
        cmd_o.finish = sts_i.settled || sts_i.bad;
        cmd_o.step   = !(sts_i.settled || sts_i.bad);
      end
      gdds_pkg::S_OUT: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdds_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/gregorian_date_day_shifter.sv =====
// Channel   Direction  Contents
// s_axis    in         request: tuser = req_type, tdata = year, month, day, offset
// m_axis    out        result: tdata = stored year, month, day, status
//
// A load transaction writes the stored date and status, which serve as the output
// register. A shift transaction copies the stored date to a working date and then
// takes year or month steps of the shared step unit: about 180 whole-year steps and
// up to 24 month steps for the widest offset, before the result is stored.
// Reset sets the stored date to 1900-01-01. The block takes one transaction
// at a time; a stalled result holds until m_axis_tready_i is high.
module gregorian_date_day_shifter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [13:0] new_year, [17:14] new_month, [22:18] new_day, [39:23] day_offset
  input  logic [39:0] s_axis_tdata_i,
  // [0] req_type
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [13:0] cur_year, [17:14] cur_month, [22:18] cur_day, [24:23] status, [31:25] zero
  output logic [31:0] m_axis_tdata_o
);

  gdds_pkg::cmd_t                   cmd;
  gdds_pkg::sts_t                   sts;
  gdds_pkg::status_e                status;
  logic [gdds_pkg::YearW-1:0]       cur_year;
  logic [gdds_pkg::MonthW-1:0]      cur_month;
  logic [gdds_pkg::DayW-1:0]        cur_day;

  // The controller sequences one transaction: accept, step until the date
  // settles or leaves the year range, then present the result.
  gdds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .req_type_i  (s_axis_tuser_i[0]),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  // The datapath holds the stored date, the working date of a shift and the
  // status of the last transaction.
  gdds_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .new_year_i   (s_axis_tdata_i[13:0]),
    .new_month_i  (s_axis_tdata_i[17:14]),
    .new_day_i    (s_axis_tdata_i[22:18]),
    .day_offset_i ($signed(s_axis_tdata_i[39:23])),
    .sts_o        (sts),
    .cur_year_o   (cur_year),
    .cur_month_o  (cur_month),
    .cur_day_o    (cur_day),
    .status_o     (status)
  );

  // The stored date and status registers serve as the output register.
  assign m_axis_tdata_o = {7'd0, status, cur_day, cur_month, cur_year};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gdds_pkg::*;

  // Margin for a shift of the widest offset to settle.
  localparam int SettleCycles = 256;
  // Cycles without any transaction on either side before the run is declared hung.
  localparam int HangLimit    = 5000;
  localparam int RandomItems  = 530;

  // Result word as it leaves the block, most significant field first.
  typedef struct packed {
    logic [6:0]        pad;
    status_e           status;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_word_t;

  // The scoreboard keeps its own copy of the stored date, predicts the result of
  // every accepted request and compares each result with the oldest prediction.
  class date_scoreboard;
    logic [YearW-1:0]  year_q;
    logic [MonthW-1:0] month_q;
    logic [DayW-1:0]   day_q;
    date_word_t        waiting[$];
    int errors;
    int results;
    int loads;
    int shifts;
    int rejected_loads;
    int range_hits;

    function new();
      year_q  = DefaultYear;
      month_q = MonthJan;
      day_q   = DayFirst;
    endfunction

    static function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int month_days(int y, int m);
      int len;
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        4, 6, 9, 11:           len = 30;
        2:                     len = leap_year(y) ? 29 : 28;
        default:               len = 0;
      endcase
      return len;
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("ERROR: %s", what);
    endfunction

    // Called once per accepted request transaction.
    function void note_request(req_e kind, logic [39:0] data);
      int y;
      int m;
      int d;
      int offset;
      bit overflow;
      date_word_t exp;
      exp = '0;
      exp.status = STATUS_OK;
      if (kind == REQ_LOAD) begin
        loads++;
        y = data[13:0];
        m = data[17:14];
        d = data[22:18];
        if (y < YearMin || y > YearMax || m < MonthJan || m > MonthDec ||
            d < 1 || d > month_days(y, m)) begin
          // An invalid date falls back to the default and is reported.
          year_q  = DefaultYear;
          month_q = MonthJan;
          day_q   = DayFirst;
          exp.status = STATUS_BAD_LOAD;
          rejected_loads++;
        end else begin
          year_q  = YearW'(y);
          month_q = MonthW'(m);
          day_q   = DayW'(d);
        end
      end else begin
        shifts++;
        offset   = $signed(data[39:23]);
        y        = year_q;
        m        = month_q;
        d        = day_q + offset;
        overflow = 1'b0;
        // Walk forward month by month while the day runs past the month end.
        while (!overflow && d > month_days(y, m)) begin
          d -= month_days(y, m);
          m++;
          if (m > MonthDec) begin
            m = MonthJan;
            y++;
            if (y > YearMax) overflow = 1'b1;
          end
        end
        // Walk backward while the day lies before the first of the month.
        while (!overflow && d < 1) begin
          m--;
          if (m < MonthJan) begin
            m = MonthDec;
            y--;
            if (y < YearMin) overflow = 1'b1;
          end
          if (!overflow) d += month_days(y, m);
        end
        if (overflow) begin
          exp.status = STATUS_RANGE;
          range_hits++;
        end else begin
          year_q  = YearW'(y);
          month_q = MonthW'(m);
          day_q   = DayW'(d);
        end
      end
      exp.year  = year_q;
      exp.month = month_q;
      exp.day   = day_q;
      waiting.push_back(exp);
    endfunction

    // Called once per accepted result transaction.
    function void check_result(logic [31:0] word);
      date_word_t got;
      date_word_t exp;
      got = word;
      results++;
      if (waiting.size() == 0) begin
        flag($sformatf("result %h arrived with no request outstanding", word));
      end else begin
        exp = waiting.pop_front();
        if (got.year != exp.year || got.month != exp.month || got.day != exp.day ||
            got.status != exp.status || got.pad != exp.pad) begin
          flag({$sformatf("result %0d: expected %0d-%0d-%0d status %0d pad %h, ",
                          results, exp.year, exp.month, exp.day, exp.status, exp.pad),
                $sformatf("got %0d-%0d-%0d status %0d pad %h",
                          got.year, got.month, got.day, got.status, got.pad)});
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;
  logic [0:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  // When cleared, both sides run back to back with no idle cycles.
  bit gaps_on = 1'b1;

  date_scoreboard board = new();

  gregorian_date_day_shifter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request words. The fields that a request type ignores carry random bits so
  // that the block is seen to ignore them.
  function automatic logic [39:0] load_word(int y, int m, int d);
    return {17'($urandom), 5'(d), 4'(m), 14'(y)};
  endfunction

  function automatic logic [39:0] shift_word(int offset);
    return {17'(offset), 23'($urandom)};
  endfunction

  // Presents one request and returns at the edge where it is accepted. Valid
  // stays high after acceptance so that back-to-back requests need no gap; it is
  // lowered only when the next request draws an idle gap or the results are drained.
  task automatic send_request(req_e kind, logic [39:0] data);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(kind, data);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Random request. Most loads carry a valid date, often close to either end of
  // the year range so that shifts run into the range limits; the rest are raw
  // field noise. Offsets mix short hops, medium spans and the full 17-bit range.
  task automatic send_random();
    int y;
    int m;
    int d;
    int offset;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      offset = $urandom_range(0, 80) - 40;
      else if (pick < 7) offset = $urandom_range(0, 2000) - 1000;
      else               offset = $signed(17'($urandom));
      send_request(REQ_SHIFT, shift_word(offset));
    end else if (pick < 87) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)      y = $urandom_range(YearMin, YearMax);
      else if (pick < 8) y = $urandom_range(1, 200);
      else               y = $urandom_range(9800, 9999);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, date_scoreboard::month_days(y, m));
      send_request(REQ_LOAD, load_word(y, m, d));
    end else begin
      send_request(REQ_LOAD, load_word($urandom_range(0, 16383), $urandom_range(0, 15),
                                        $urandom_range(0, 31)));
    end
  endtask

  // Result side: draws a stall before each result, ready stays high otherwise.
  initial begin : result_sink
    int stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = gaps_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      board.check_result(m_axis_tdata_o);
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  initial begin : hang_watch
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < HangLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles", HangLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A zero shift right after reset returns the reset date.
    send_request(REQ_SHIFT, shift_word(0));
    // Leap-year rule: divisible by 400 is leap, a plain century is not.
    send_request(REQ_LOAD, load_word(2000, 2, 29));
    send_request(REQ_LOAD, load_word(1900, 2, 29));
    send_request(REQ_LOAD, load_word(2024, 2, 29));
    send_request(REQ_LOAD, load_word(2023, 2, 29));
    // Year zero and a year above 9999 (all year bits set) are rejected.
    send_request(REQ_LOAD, load_word(0, 5, 10));
    send_request(REQ_LOAD, load_word(16383, 12, 31));
    // Illegal months and days.
    send_request(REQ_LOAD, load_word(2021, 0, 10));
    send_request(REQ_LOAD, load_word(2021, 13, 10));
    send_request(REQ_LOAD, load_word(2021, 15, 31));
    send_request(REQ_LOAD, load_word(2021, 4, 31));
    send_request(REQ_LOAD, load_word(2021, 1, 0));
    send_request(REQ_LOAD, load_word(2021, 1, 31));
    // Stepping past the last representable day leaves the date alone.
    send_request(REQ_LOAD, load_word(9999, 12, 31));
    send_request(REQ_SHIFT, shift_word(1));
    send_request(REQ_SHIFT, shift_word(-65536));
    send_request(REQ_SHIFT, shift_word(0));
    // Stepping before the first representable day leaves the date alone.
    send_request(REQ_LOAD, load_word(1, 1, 1));
    send_request(REQ_SHIFT, shift_word(-1));
    send_request(REQ_SHIFT, shift_word(65535));
    send_request(REQ_SHIFT, shift_word(-65536));
    send_request(REQ_LOAD, load_word(1, 1, 1));
    send_request(REQ_SHIFT, shift_word(-65536));

    // Random part, in blocks of 60 with every third block at full rate. Halfway
    // through, the sender holds off until every outstanding result is back.
    for (int i = 0; i < RandomItems; i++) begin
      gaps_on = ((i / 60) % 3) != 2;
      if (i == RandomItems / 2) drain_results();
      send_random();
    end

    gaps_on = 1'b1;
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.pending() != 0)
      board.flag($sformatf("%0d results never arrived", board.pending()));

    $display("Run covered %0d loads (%0d rejected) and %0d shifts (%0d out of range).",
             board.loads, board.rejected_loads, board.shifts, board.range_hits);
    $display("Checked %0d results, %0d errors.", board.results, board.errors);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== gregorian_date_day_shifter.f =====
rtl/core/gdds_pkg.sv
rtl/core/gdds_dp.sv
rtl/core/gdds_ctrl.sv
rtl/core/gregorian_date_day_shifter.sv
sim/tb.sv
